// ===== sv/agm_pkg.sv =====
// ----------------------------------------------------------------------------
// agm_pkg
// Shared request types, path codes and the command passed from the front
// end to the back end of the gap merge block.
// ----------------------------------------------------------------------------
package agm_pkg;

    localparam int GAP_W = 13;

    localparam logic KIND_PATH = 1'b0;
    localparam logic KIND_GAP  = 1'b1;

    typedef enum logic [1:0] {
        PATH_MATCH = 2'd0,
        PATH_GAP_A = 2'd1,
        PATH_GAP_B = 2'd2,
        PATH_END   = 2'd3
    } t_path_code;

    typedef struct packed {
        logic             kind;
        logic [1:0]       path_code;
        logic             side;
        logic [GAP_W-1:0] old_gap;
        logic             first_item;
        logic             last_entry;
    } t_in_req;

    typedef struct packed {
        logic [GAP_W-1:0] new_gap;
        logic             overflow;
        logic             is_last;
    } t_out_req;

    typedef struct packed {
        logic             is_gap;
        logic             clear;
        logic [1:0]       code;
        logic             side;
        logic             last;
        logic             win_ovf;
        logic             empty;
        logic [GAP_W-1:0] gap;
    } t_cmd;

endpackage

// ===== sv/agm_front.sv =====
// ----------------------------------------------------------------------------
// agm_front
// Classifies accepted requests, drops path steps after a path end and
// tracks the running window to produce read ranges for gap entries.
// ----------------------------------------------------------------------------
module agm_front #(
    parameter int MAX_LEN = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_take,
    input  agm_pkg::t_in_req                  i_req,
    output logic                              o_push,
    output agm_pkg::t_cmd                     o_cmd,
    output logic [$clog2(MAX_LEN+1)-1:0]      o_start,
    output logic [$clog2(MAX_LEN+1)-1:0]      o_stop
);
    import agm_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN + 1);
    localparam int WS_W  = $clog2(MAX_LEN + 2);
    localparam int E_W   = ((WS_W > GAP_W) ? WS_W : GAP_W) + 1;
    localparam logic [E_W-1:0] MAX_E = E_W'(MAX_LEN);
    localparam logic [E_W-1:0] LIM_E = E_W'(MAX_LEN + 1);

    logic            r_ended;
    logic            n_ended;
    logic [WS_W-1:0] r_ws;
    logic [WS_W-1:0] n_ws;
    logic [WS_W-1:0] ws_eff;
    logic [E_W-1:0]  end_e;
    logic [E_W-1:0]  next_e;
    logic            is_gap;
    logic            ended_eff;
    logic            win_ovf;

    assign is_gap    = (i_req.kind == KIND_GAP);
    assign ws_eff    = i_req.first_item ? '0 : r_ws;
    assign end_e     = E_W'(ws_eff) + E_W'(i_req.old_gap);
    assign next_e    = end_e + E_W'(1);
    assign win_ovf   = (end_e > MAX_E);
    assign ended_eff = i_req.first_item ? 1'b0 : r_ended;

    always_comb begin
        o_cmd.is_gap  = is_gap;
        o_cmd.clear   = i_req.first_item;
        o_cmd.code    = i_req.path_code;
        o_cmd.side    = i_req.side;
        o_cmd.last    = i_req.last_entry;
        o_cmd.win_ovf = win_ovf;
        o_cmd.empty   = (E_W'(ws_eff) > MAX_E);
        o_cmd.gap     = i_req.old_gap;
        o_start       = ws_eff[IDX_W-1:0];
        o_stop        = win_ovf ? IDX_W'(MAX_LEN) : end_e[IDX_W-1:0];
        o_push        = i_take & (is_gap | i_req.first_item | ~r_ended);

        n_ended = r_ended;
        n_ws    = r_ws;
        if (i_take) begin
            if (is_gap) begin
                if (i_req.last_entry) begin
                    n_ws = '0;
                end else if (next_e > LIM_E) begin
                    n_ws = LIM_E[WS_W-1:0];
                end else begin
                    n_ws = next_e[WS_W-1:0];
                end
            end else begin
                n_ended = ended_eff | (i_req.path_code == PATH_END);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended <= 1'b0;
            r_ws    <= '0;
        end else begin
            r_ended <= n_ended;
            r_ws    <= n_ws;
        end
    end

endmodule

// ===== sv/agm_queue.sv =====
// ----------------------------------------------------------------------------
// agm_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module agm_queue #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_nonempty
);
    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_data     = r_mem[r_rp];
    assign o_full     = (r_cnt == CNT_W'(DEPTH));
    assign o_nonempty = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== sv/agm_back.sv =====
// ----------------------------------------------------------------------------
// agm_back
// Holds both gap count stores, applies path steps and sums the window of
// each gap entry one store read per cycle into the output register.
// ----------------------------------------------------------------------------
module agm_back #(
    parameter int MAX_LEN = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  agm_pkg::t_cmd                     i_cmd,
    input  logic [$clog2(MAX_LEN+1)-1:0]      i_start,
    input  logic [$clog2(MAX_LEN+1)-1:0]      i_stop,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output agm_pkg::t_out_req                 o_out_req
);
    import agm_pkg::*;

    localparam int IDX_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int ACC_W0 = $clog2(2 * MAX_LEN + 3);
    localparam int ACC_W  = (ACC_W0 > GAP_W + 1) ? ACC_W0 : GAP_W + 1;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_LEN);
    localparam logic [ACC_W-1:0] ACC_MAX = ACC_W'(MAX_LEN);
    localparam logic [ACC_W-1:0] ACC_LIM = ACC_W'(MAX_LEN + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state r_state, n_state;

    logic [IDX_W-1:0]  mem_a [MAX_LEN];
    logic [IDX_W-1:0]  mem_b [MAX_LEN];
    logic [IDX_W-1:0]  r_q_a;
    logic [IDX_W-1:0]  r_q_b;
    logic [ADDR_W-1:0] rd_addr;
    logic              we_a, we_b;
    logic [ADDR_W-1:0] wa_a, wa_b;
    logic [IDX_W-1:0]  wd_a, wd_b;

    logic [IDX_W-1:0]  r_pos_a, r_pos_b, r_cur_a, r_cur_b;
    logic [IDX_W-1:0]  n_pos_a, n_pos_b, n_cur_a, n_cur_b;
    logic [IDX_W-1:0]  base_pos_a, base_pos_b, base_cur_a, base_cur_b;
    logic [IDX_W-1:0]  pos_s, cur_s;

    logic [IDX_W-1:0]  r_j, n_j, r_stop, n_stop;
    logic [IDX_W-1:0]  r_alt, n_alt;
    logic              r_use_mem, n_use_mem;
    logic              r_pend, n_pend;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [ACC_W-1:0]  acc_sum;
    logic [IDX_W-1:0]  rd_data;
    logic              r_side, n_side;
    logic              r_last, n_last;
    logic              r_wovf, n_wovf;
    logic              r_out_valid, n_out_valid;
    t_out_req          r_out, n_out;
    logic              out_free;
    logic              total_ovf;
    logic              adv_a, adv_b;

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;
    assign o_pop       = (r_state == S_IDLE) && i_cmd_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign pos_s     = r_side ? r_pos_b : r_pos_a;
    assign cur_s     = r_side ? r_cur_b : r_cur_a;
    assign rd_addr   = r_j[ADDR_W-1:0];
    assign rd_data   = r_use_mem ? (r_side ? r_q_b : r_q_a) : r_alt;
    assign acc_sum   = r_acc + ACC_W'(rd_data);
    assign total_ovf = (r_acc > ACC_MAX);

    assign base_pos_a = i_cmd.clear ? '0 : r_pos_a;
    assign base_pos_b = i_cmd.clear ? '0 : r_pos_b;
    assign base_cur_a = i_cmd.clear ? '0 : r_cur_a;
    assign base_cur_b = i_cmd.clear ? '0 : r_cur_b;
    assign adv_a = (i_cmd.code == PATH_MATCH) || (i_cmd.code == PATH_GAP_B);
    assign adv_b = (i_cmd.code == PATH_MATCH) || (i_cmd.code == PATH_GAP_A);

    always_comb begin
        n_state     = r_state;
        n_pos_a     = r_pos_a;
        n_pos_b     = r_pos_b;
        n_cur_a     = r_cur_a;
        n_cur_b     = r_cur_b;
        n_j         = r_j;
        n_stop      = r_stop;
        n_alt       = r_alt;
        n_use_mem   = r_use_mem;
        n_pend      = 1'b0;
        n_acc       = r_pend ? ((acc_sum > ACC_LIM) ? ACC_LIM : acc_sum) : r_acc;
        n_side      = r_side;
        n_last      = r_last;
        n_wovf      = r_wovf;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        we_a        = 1'b0;
        we_b        = 1'b0;
        wa_a        = base_pos_a[ADDR_W-1:0];
        wa_b        = base_pos_b[ADDR_W-1:0];
        wd_a        = base_cur_a;
        wd_b        = base_cur_b;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.is_gap) begin
                        n_j    = i_start;
                        n_stop = i_stop;
                        n_side = i_cmd.side;
                        n_last = i_cmd.last;
                        n_wovf = i_cmd.win_ovf;
                        n_acc  = (ACC_W'(i_cmd.gap) > ACC_LIM) ? ACC_LIM
                                                                : ACC_W'(i_cmd.gap);
                        n_state = i_cmd.empty ? S_FIN : S_READ;
                    end else begin
                        n_pos_a = base_pos_a;
                        n_cur_a = base_cur_a;
                        n_pos_b = base_pos_b;
                        n_cur_b = base_cur_b;
                        if (adv_a && base_pos_a != IDX_MAX) begin
                            we_a    = 1'b1;
                            n_pos_a = base_pos_a + IDX_W'(1);
                            n_cur_a = '0;
                        end else if (i_cmd.code == PATH_GAP_A && base_cur_a != IDX_MAX) begin
                            n_cur_a = base_cur_a + IDX_W'(1);
                        end
                        if (adv_b && base_pos_b != IDX_MAX) begin
                            we_b    = 1'b1;
                            n_pos_b = base_pos_b + IDX_W'(1);
                            n_cur_b = '0;
                        end else if (i_cmd.code == PATH_GAP_B && base_cur_b != IDX_MAX) begin
                            n_cur_b = base_cur_b + IDX_W'(1);
                        end
                    end
                end
            end
            S_READ: begin
                n_pend    = 1'b1;
                n_use_mem = (r_j < pos_s);
                n_alt     = (r_j == pos_s) ? cur_s : '0;
                n_j       = r_j + IDX_W'(1);
                if (r_j == r_stop) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_out.new_gap  = total_ovf ? ACC_MAX[GAP_W-1:0] : r_acc[GAP_W-1:0];
                    n_out.overflow = total_ovf | r_wovf;
                    n_out.is_last  = r_last;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            mem_a[wa_a] <= wd_a;
        end
        if (we_b) begin
            mem_b[wa_b] <= wd_b;
        end
        r_q_a <= mem_a[rd_addr];
        r_q_b <= mem_b[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos_a     <= '0;
            r_pos_b     <= '0;
            r_cur_a     <= '0;
            r_cur_b     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos_a     <= n_pos_a;
            r_pos_b     <= n_pos_b;
            r_cur_a     <= n_cur_a;
            r_cur_b     <= n_cur_b;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_j       <= n_j;
        r_stop    <= n_stop;
        r_alt     <= n_alt;
        r_use_mem <= n_use_mem;
        r_acc     <= n_acc;
        r_side    <= n_side;
        r_last    <= n_last;
        r_wovf    <= n_wovf;
        r_out     <= n_out;
    end

endmodule

// ===== sv/alignment_gap_merge.sv =====
// ----------------------------------------------------------------------------
// alignment_gap_merge
// Merges the gaps of a pairwise alignment path into member gap vectors.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_req) takes path steps and
// gap entries in one ordered stream; output channel (o_out_valid /
// i_out_stall / o_out_req) returns one request per gap entry, none per
// path step. A front end queues up to two commands ahead of the back end.
// Path step: applied in the back end cycle that takes it off the queue.
// Gap entry: one store read per window position in the read state, then
// the drain and finish states load the output register; the window
// holds old_gap + 1 positions clipped at MAX_LEN, and a window that starts
// past the store skips the reads and goes straight to the finish state.
// The store read port sets the rate: the back end takes no new command
// until the finish state has handed the gap entry to the output register.
// Each side store is a MAX_LEN deep memory filled behind a position
// pointer; entries past the pointer read as zero, so neither reset nor a
// new path needs a clearing pass. Reset empties queue and output register.
// While the receiver stalls the output holds; the back end still applies
// path steps and sums the next gap entry, then waits to hand it over.
// ----------------------------------------------------------------------------
module alignment_gap_merge #(
    parameter int MAX_LEN = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  agm_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output agm_pkg::t_out_req o_out_req
);
    import agm_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN + 1);
    localparam int CMD_W = $bits(t_cmd);
    localparam int Q_W   = CMD_W + 2 * IDX_W;

    logic             in_take;
    logic             f_push;
    t_cmd             f_cmd;
    logic [IDX_W-1:0] f_start;
    logic [IDX_W-1:0] f_stop;
    logic [Q_W-1:0]   q_din;
    logic [Q_W-1:0]   q_dout;
    logic             q_full;
    logic             q_nonempty;
    logic             q_pop;
    t_cmd             b_cmd;
    logic [IDX_W-1:0] b_start;
    logic [IDX_W-1:0] b_stop;

    assign o_in_stall = q_full;
    assign in_take    = i_in_valid && !q_full;
    assign q_din      = {f_cmd, f_start, f_stop};
    assign b_cmd      = t_cmd'(q_dout[Q_W-1 -: CMD_W]);
    assign b_start    = q_dout[2*IDX_W-1 -: IDX_W];
    assign b_stop     = q_dout[IDX_W-1:0];

    agm_front #(
        .MAX_LEN(MAX_LEN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_take),
        .i_req   (i_in_req),
        .o_push  (f_push),
        .o_cmd   (f_cmd),
        .o_start (f_start),
        .o_stop  (f_stop)
    );

    agm_queue #(
        .W(Q_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (f_push),
        .i_data     (q_din),
        .i_pop      (q_pop),
        .o_data     (q_dout),
        .o_full     (q_full),
        .o_nonempty (q_nonempty)
    );

    agm_back #(
        .MAX_LEN(MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_nonempty),
        .i_cmd       (b_cmd),
        .i_start     (b_start),
        .i_stop      (b_stop),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

`ifndef NO_ASSERTIONS
    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_nonempty)
        else $error("back end popped an empty queue");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_result_not_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(q_pop))
        else $error("result loaded in a cycle that took a command");
`endif

endmodule
